// ===== src/obe_pkg.sv =====
// ---------------------------------------------------------------------------
// Oriented box extent package
// Shared widths, reset values, command word and multiply step codes.
// ---------------------------------------------------------------------------
`default_nettype none

package obe_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned DiffW   = CoordW + 1;
  localparam int unsigned CompW   = 16;
  localparam int unsigned AxisW   = 3 * CompW;
  localparam int unsigned ProjW   = 36;
  localparam int unsigned ExtW    = 36;
  localparam int unsigned ResW    = 64;
  localparam int unsigned NumAxes = 3;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 64;

  // Reset values of the three axes: unit vectors along x, y and z.
  localparam logic [AxisW-1:0] AxisAReset = 48'h0000_0000_4000;
  localparam logic [AxisW-1:0] AxisBReset = 48'h0000_4000_0000;
  localparam logic [AxisW-1:0] AxisCReset = 48'h4000_0000_0000;

  // Register indexes on the configuration port.
  localparam logic [1:0] RegAxisA = 2'd0;
  localparam logic [1:0] RegAxisB = 2'd1;
  localparam logic [1:0] RegAxisC = 2'd2;

  // Steps of the shared 36 x 18 multiplier for volume and area.
  localparam logic [3:0] StepAbLo   = 4'd0;
  localparam logic [3:0] StepAbHi   = 4'd1;
  localparam logic [3:0] StepVol0   = 4'd2;
  localparam logic [3:0] StepVol1   = 4'd3;
  localparam logic [3:0] StepVol2   = 4'd4;
  localparam logic [3:0] StepVol3   = 4'd5;
  localparam logic [3:0] StepAreaAb0 = 4'd6;
  localparam logic [3:0] StepAreaAb1 = 4'd7;
  localparam logic [3:0] StepAreaBc0 = 4'd8;
  localparam logic [3:0] StepAreaBc1 = 4'd9;
  localparam logic [3:0] StepAreaCa0 = 4'd10;
  localparam logic [3:0] StepAreaCa1 = 4'd11;
  localparam logic [3:0] StepLast    = StepAreaCa1;

  typedef logic [NumAxes-1:0][AxisW-1:0] obe_axes_t;

  typedef enum logic [1:0] {
    DEST_AB   = 2'd0,
    DEST_VOL  = 2'd1,
    DEST_AREA = 2'd2
  } obe_dest_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       take_point;
    logic       first_point;
    logic       proj_mul;
    logic       proj_acc;
    logic [1:0] axis;
    logic       ext;
    logic       step_mul;
    logic       step_acc;
    logic [3:0] step;
    logic       load_out;
  } obe_cmd_t;

endpackage

`default_nettype wire

// ===== src/obe_regs.sv =====
// ---------------------------------------------------------------------------
// Oriented box extent axis registers
// APB-style register bank holding the three box axes.
// ---------------------------------------------------------------------------
`default_nettype none

module obe_regs (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [obe_pkg::AddrW-1:0] paddr,
  input  wire logic [obe_pkg::DataW-1:0] pwdata,
  output logic      [obe_pkg::DataW-1:0] prdata,
  output logic                           pready,
  output obe_pkg::obe_axes_t             axes_o
);
  import obe_pkg::*;

  logic [AxisW-1:0] axis_a_q, axis_b_q, axis_c_q;
  logic [1:0]       reg_idx;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrW-1:3];
  assign wr_en   = psel && penable && pwrite;

  // Register writes keep the low 48 bits; writes beyond the bank are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_a_q <= AxisAReset;
      axis_b_q <= AxisBReset;
      axis_c_q <= AxisCReset;
    end else if (wr_en) begin
      case (reg_idx)
        RegAxisA: axis_a_q <= pwdata[AxisW-1:0];
        RegAxisB: axis_b_q <= pwdata[AxisW-1:0];
        RegAxisC: axis_c_q <= pwdata[AxisW-1:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (reg_idx)
      RegAxisA: prdata = {{(DataW-AxisW){1'b0}}, axis_a_q};
      RegAxisB: prdata = {{(DataW-AxisW){1'b0}}, axis_b_q};
      RegAxisC: prdata = {{(DataW-AxisW){1'b0}}, axis_c_q};
      default:  prdata = '0;
    endcase
  end

  assign axes_o[0] = axis_a_q;
  assign axes_o[1] = axis_b_q;
  assign axes_o[2] = axis_c_q;

endmodule

`default_nettype wire

// ===== src/obe_ctrl.sv =====
// ---------------------------------------------------------------------------
// Oriented box extent controller
// Sequences projection, extent and multiply steps and owns the handshakes.
// ---------------------------------------------------------------------------
`default_nettype none

module obe_ctrl (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      last_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output obe_pkg::obe_cmd_t cmd_o
);
  import obe_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MUL  = 7'b0000010,
    S_ACC  = 7'b0000100,
    S_EXT  = 7'b0001000,
    S_SMUL = 7'b0010000,
    S_SACC = 7'b0100000,
    S_OUT  = 7'b1000000
  } obe_state_e;

  obe_state_e state_q, state_d;
  logic [1:0] cnt_q, cnt_d;
  logic [3:0] step_q, step_d;
  logic       in_run_q, in_run_d;
  logic       last_q, last_d;
  logic       out_valid_q, out_valid_d;
  logic       in_take;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_take     = in_valid_i && (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and commands.
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    step_d   = step_q;
    in_run_d = in_run_q;
    last_d   = last_q;
    cmd_o    = '0;
    cmd_o.axis = cnt_q;
    cmd_o.step = step_q;
    case (state_q)
      S_IDLE: begin
        if (in_take) begin
          cmd_o.take_point  = 1'b1;
          cmd_o.first_point = !in_run_q;
          last_d   = last_i;
          in_run_d = !last_i;
          cnt_d    = '0;
          if (!in_run_q) begin
            state_d = last_i ? S_EXT : S_IDLE;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd_o.proj_mul = 1'b1;
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.proj_acc = 1'b1;
        if (cnt_q == 2'(NumAxes - 1)) begin
          cnt_d   = '0;
          state_d = last_q ? S_EXT : S_IDLE;
        end else begin
          cnt_d   = cnt_q + 2'd1;
          state_d = S_MUL;
        end
      end
      S_EXT: begin
        cmd_o.ext = 1'b1;
        step_d  = '0;
        state_d = S_SMUL;
      end
      S_SMUL: begin
        cmd_o.step_mul = 1'b1;
        state_d = S_SACC;
      end
      S_SACC: begin
        cmd_o.step_acc = 1'b1;
        if (step_q == StepLast) begin
          state_d = S_OUT;
        end else begin
          step_d  = step_q + 4'd1;
          state_d = S_SMUL;
        end
      end
      S_OUT: begin
        // The output register is free or is being emptied in this cycle.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output word valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      step_q      <= '0;
      in_run_q    <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      step_q      <= step_d;
      in_run_q    <= in_run_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/obe_dp.sv =====
// ---------------------------------------------------------------------------
// Oriented box extent datapath
// Reference point, projection bounds, extents and the shared multiplier.
// ---------------------------------------------------------------------------
`default_nettype none

module obe_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire obe_pkg::obe_cmd_t                 cmd_i,
  input  wire obe_pkg::obe_axes_t                axes_i,
  input  wire logic signed [obe_pkg::CoordW-1:0] px_i,
  input  wire logic signed [obe_pkg::CoordW-1:0] py_i,
  input  wire logic signed [obe_pkg::CoordW-1:0] pz_i,
  output logic             [obe_pkg::ExtW-1:0]   extent_a_o,
  output logic             [obe_pkg::ExtW-1:0]   extent_b_o,
  output logic             [obe_pkg::ExtW-1:0]   extent_c_o,
  output logic             [obe_pkg::ResW-1:0]   volume_o,
  output logic             [obe_pkg::ResW-1:0]   area_o
);
  import obe_pkg::*;

  localparam int unsigned ProdW  = DiffW + CompW;
  localparam int unsigned SumW   = ProdW + 2;
  localparam int unsigned MopBW  = 18;
  localparam int unsigned MprodW = ExtW + MopBW;
  localparam int unsigned AbW    = 2 * ExtW;
  localparam int unsigned VolW   = 3 * ExtW;
  localparam int unsigned AreaW  = AbW + 2;

  logic signed [CoordW-1:0] ref_q [NumAxes];
  logic signed [DiffW-1:0]  d_q   [NumAxes];
  logic signed [ProjW-1:0]  min_q [NumAxes];
  logic signed [ProjW-1:0]  max_q [NumAxes];
  logic signed [ProdW-1:0]  pp_q  [NumAxes];
  logic signed [ProdW-1:0]  pp_d  [NumAxes];
  logic [ExtW-1:0]          ext_q [NumAxes];
  logic [AxisW-1:0]         axis_sel;
  logic signed [CoordW-1:0] pt    [NumAxes];
  logic signed [SumW-1:0]   psum;
  logic signed [ProjW-1:0]  proj;

  logic [ExtW-1:0]   mop_a;
  logic [MopBW-1:0]  mop_b;
  logic [5:0]        msh_d, msh_q;
  obe_dest_e         mdest_d, mdest_q;
  logic [MprodW-1:0] mprod_q;
  logic [VolW-1:0]   mterm;
  logic [AbW-1:0]    ab_q;
  logic [VolW-1:0]   vol_q;
  logic [AreaW-1:0]  area_q;

  assign pt[0] = px_i;
  assign pt[1] = py_i;
  assign pt[2] = pz_i;
  assign axis_sel = axes_i[cmd_i.axis];

  // Reference point on the first point of a run, else the difference to it.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NumAxes; k++) begin
      if (cmd_i.take_point) begin
        if (cmd_i.first_point) begin
          ref_q[k] <= pt[k];
        end else begin
          d_q[k] <= DiffW'(pt[k]) - DiffW'(ref_q[k]);
        end
      end
    end
  end

  // Three component products of the difference with the selected axis.
  always_comb begin
    for (int k = 0; k < NumAxes; k++) begin
      pp_d[k] = d_q[k] * $signed(axis_sel[k*CompW +: CompW]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.proj_mul) begin
      for (int k = 0; k < NumAxes; k++) begin
        pp_q[k] <= pp_d[k];
      end
    end
  end

  // Sum, floor shift by 14 and bound update for one axis.
  assign psum = SumW'(pp_q[0]) + SumW'(pp_q[1]) + SumW'(pp_q[2]);
  assign proj = $signed(psum[14 +: ProjW]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_point && cmd_i.first_point) begin
      for (int k = 0; k < NumAxes; k++) begin
        min_q[k] <= '0;
        max_q[k] <= '0;
      end
    end else if (cmd_i.proj_acc) begin
      if (proj < min_q[cmd_i.axis]) begin
        min_q[cmd_i.axis] <= proj;
      end
      if (proj > max_q[cmd_i.axis]) begin
        max_q[cmd_i.axis] <= proj;
      end
    end
  end

  // Extents.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ext) begin
      for (int k = 0; k < NumAxes; k++) begin
        ext_q[k] <= ExtW'(max_q[k] - min_q[k]);
      end
    end
  end

  // Operand selection for each multiply step.
  always_comb begin
    mop_a   = ext_q[0];
    mop_b   = ext_q[1][MopBW-1:0];
    msh_d   = 6'd0;
    mdest_d = DEST_AB;
    case (cmd_i.step)
      StepAbLo: begin
        mop_a = ext_q[0]; mop_b = ext_q[1][MopBW-1:0];
        msh_d = 6'd0;  mdest_d = DEST_AB;
      end
      StepAbHi: begin
        mop_a = ext_q[0]; mop_b = ext_q[1][ExtW-1:MopBW];
        msh_d = 6'd18; mdest_d = DEST_AB;
      end
      StepVol0: begin
        mop_a = ext_q[2]; mop_b = ab_q[17:0];
        msh_d = 6'd0;  mdest_d = DEST_VOL;
      end
      StepVol1: begin
        mop_a = ext_q[2]; mop_b = ab_q[35:18];
        msh_d = 6'd18; mdest_d = DEST_VOL;
      end
      StepVol2: begin
        mop_a = ext_q[2]; mop_b = ab_q[53:36];
        msh_d = 6'd36; mdest_d = DEST_VOL;
      end
      StepVol3: begin
        mop_a = ext_q[2]; mop_b = ab_q[71:54];
        msh_d = 6'd54; mdest_d = DEST_VOL;
      end
      StepAreaAb0: begin
        mop_a = ext_q[0]; mop_b = ext_q[1][MopBW-1:0];
        msh_d = 6'd0;  mdest_d = DEST_AREA;
      end
      StepAreaAb1: begin
        mop_a = ext_q[0]; mop_b = ext_q[1][ExtW-1:MopBW];
        msh_d = 6'd18; mdest_d = DEST_AREA;
      end
      StepAreaBc0: begin
        mop_a = ext_q[1]; mop_b = ext_q[2][MopBW-1:0];
        msh_d = 6'd0;  mdest_d = DEST_AREA;
      end
      StepAreaBc1: begin
        mop_a = ext_q[1]; mop_b = ext_q[2][ExtW-1:MopBW];
        msh_d = 6'd18; mdest_d = DEST_AREA;
      end
      StepAreaCa0: begin
        mop_a = ext_q[2]; mop_b = ext_q[0][MopBW-1:0];
        msh_d = 6'd0;  mdest_d = DEST_AREA;
      end
      StepAreaCa1: begin
        mop_a = ext_q[2]; mop_b = ext_q[0][ExtW-1:MopBW];
        msh_d = 6'd18; mdest_d = DEST_AREA;
      end
      default: ;
    endcase
  end

  // Shared 36 x 18 multiplier, registered with its shift and destination.
  always_ff @(posedge clk_i) begin
    if (cmd_i.step_mul) begin
      mprod_q <= mop_a * mop_b;
      msh_q   <= msh_d;
      mdest_q <= mdest_d;
    end
  end

  assign mterm = VolW'(mprod_q) << msh_q;

  // Accumulation of partial products; cleared when the extents are taken.
  always_ff @(posedge clk_i) begin
    if (cmd_i.ext) begin
      ab_q   <= '0;
      vol_q  <= '0;
      area_q <= '0;
    end else if (cmd_i.step_acc) begin
      case (mdest_q)
        DEST_AB:   ab_q   <= ab_q + mterm[AbW-1:0];
        DEST_VOL:  vol_q  <= vol_q + mterm;
        DEST_AREA: area_q <= area_q + mterm[AreaW-1:0];
        default: ;
      endcase
    end
  end

  // Output word; the volume is the product of three extents shifted down by 32 bits and saturates above 96 bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      extent_a_o <= '0;
      extent_b_o <= '0;
      extent_c_o <= '0;
      volume_o   <= '0;
      area_o     <= '0;
    end else if (cmd_i.load_out) begin
      extent_a_o <= ext_q[0];
      extent_b_o <= ext_q[1];
      extent_c_o <= ext_q[2];
      if (vol_q[VolW-1:96] != '0) begin
        volume_o <= '1;
      end else begin
        volume_o <= vol_q[95:32];
      end
      area_o <= ResW'(area_q[AreaW-1:15]);
    end
  end

endmodule

`default_nettype wire

// ===== src/oriented_box_extent.sv =====
// ---------------------------------------------------------------------------
// Oriented box extent
// Extents, volume and area of a point run along three configured axes.
// ---------------------------------------------------------------------------
// Points arrive on the input channel (px_i, py_i, pz_i, last_i) under
// in_valid_i / in_stall_o; a word is taken when valid is high and stall low.
// The first point of a run becomes the reference. Each later point is
// projected on the three axes one axis at a time through a multiply step
// and a sum-and-compare step, and the input stays stalled until all three
// axes are done.
// On the point flagged last, the extents are formed and volume and area
// follow from twelve steps of a shared 36 x 18 multiplier, each step a
// multiply state and an accumulate state; the result word is then loaded
// into the output register.
// The result is held in an output register under out_valid_o / out_stall_i;
// the block keeps taking points while it waits, and only blocks when a
// second result is ready before the first has been taken.
// The axes are written through the APB-style port at byte addresses 0, 8
// and 16. Reset restores the unit axes and starts a fresh run.
// ---------------------------------------------------------------------------
`default_nettype none

module oriented_box_extent (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic        [obe_pkg::AddrW-1:0]  paddr,
  input  wire logic        [obe_pkg::DataW-1:0]  pwdata,
  output logic             [obe_pkg::DataW-1:0]  prdata,
  output logic                                   pready,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [obe_pkg::CoordW-1:0] px_i,
  input  wire logic signed [obe_pkg::CoordW-1:0] py_i,
  input  wire logic signed [obe_pkg::CoordW-1:0] pz_i,
  input  wire logic                              last_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic             [obe_pkg::ExtW-1:0]   extent_a_o,
  output logic             [obe_pkg::ExtW-1:0]   extent_b_o,
  output logic             [obe_pkg::ExtW-1:0]   extent_c_o,
  output logic             [obe_pkg::ResW-1:0]   volume_o,
  output logic             [obe_pkg::ResW-1:0]   area_o
);
  import obe_pkg::*;

  obe_axes_t axes;
  obe_cmd_t  cmd;

  obe_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .axes_o  (axes)
  );

  obe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_i      (last_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  obe_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .axes_i     (axes),
    .px_i       (px_i),
    .py_i       (py_i),
    .pz_i       (pz_i),
    .extent_a_o (extent_a_o),
    .extent_b_o (extent_b_o),
    .extent_c_o (extent_c_o),
    .volume_o   (volume_o),
    .area_o     (area_o)
  );

endmodule

`default_nettype wire
